/* sv/peer_peak_table_with_aging_macros.svh */
`ifndef PEER_PEAK_TABLE_WITH_AGING_MACROS_SVH
`define PEER_PEAK_TABLE_WITH_AGING_MACROS_SVH

// clocked check, quiet while reset is low
`define PPTA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is low
`define PPTA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ppta_pkg.sv */
package ppta_pkg;

    localparam int DEF_MAX_PEERS = 16;
    localparam int DEF_ID_BITS   = 64;

    localparam int PID_W    = 64;
    localparam int PEAK_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 32;
    localparam int DROP_W   = 5;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    // input tdata layout
    localparam int PID_LSB    = 0;
    localparam int PPEAK_LSB  = PID_LSB + PID_W;
    localparam int PPRIO_LSB  = PPEAK_LSB + PEAK_W;
    localparam int NOW_LSB    = PPRIO_LSB + PRIO_W;
    localparam int OPEAK_LSB  = NOW_LSB + TIME_W;
    localparam int LINK_LSB   = OPEAK_LSB + PEAK_W;
    localparam int S_TDATA_W  = ((LINK_LSB + 1 + 7) / 8) * 8;

    // output tdata layout
    localparam int NET_LSB    = 0;
    localparam int PUBPK_LSB  = NET_LSB + PEAK_W;
    localparam int PUBPR_LSB  = PUBPK_LSB + PEAK_W;
    localparam int DROP_LSB   = PUBPR_LSB + PRIO_W;
    localparam int M_TDATA_W  = ((DROP_LSB + DROP_W + 7) / 8) * 8;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDENTITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_PERIOD   = 2'd3;

    localparam logic [CFG_W-1:0]  RST_OWN_IDENTITY = 64'd0;
    localparam logic [PRIO_W-1:0] RST_PRIORITY     = 8'd5;
    localparam logic [TIME_W-1:0] RST_STALE_LIMIT  = 32'd60000;
    localparam logic [TIME_W-1:0] RST_PUB_PERIOD   = 32'd15000;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED   = 3'd0,
        ST_STORED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_DUE   = 3'd3,
        ST_PUBLISHED = 3'd4,
        ST_LINK_DOWN = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_COMMIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic walk;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic early_done;
        logic walk_done;
    } dp_stat_t;

endpackage

/* sv/peer_peak_table_with_aging.sv */
// channel  | direction | tdata (lsb first)                                   | tuser
// s_       | in        | peer_id, peer_peak_w, peer_priority, now_ms,        | operation
//          |           | own_peak_w, link_ready                              |
// m_       | out       | network_peak_w, publish_peak_w, publish_priority,   | status
//          |           | stale_dropped                                       |
// cfg_     | in        | cfg_index selects the register, cfg_data the value  | -
//
// one item at a time: a report or a due tick walks the table memories over every slot
// in use, at one entry a cycle, before its result is shown; an ignored report or a tick
// not due skips the walk and goes straight to its result.
// reset clears the active flags, slot count and publish time at once; no clearing pass.
// a stalled result is held in the output register while the next item is taken in.
module peer_peak_table_with_aging
#(
    parameter int MAX_PEERS = ppta_pkg::DEF_MAX_PEERS,
    parameter int ID_BITS   = ppta_pkg::DEF_ID_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // peer_id, peer_peak_w, peer_priority, now_ms, own_peak_w, link_ready
    input  logic [ppta_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // network_peak_w, publish_peak_w, publish_priority, stale_dropped
    output logic [ppta_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [ppta_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                              cfg_we,
    input  logic [ppta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppta_pkg::CFG_W-1:0]        cfg_data
);

    ppta_pkg::dp_cmd_t                  cmd;
    ppta_pkg::dp_stat_t                 stat;
    ppta_pkg::status_t                  status;
    logic signed [ppta_pkg::PEAK_W-1:0] network_peak_w;
    logic signed [ppta_pkg::PEAK_W-1:0] publish_peak_w;
    logic [ppta_pkg::PRIO_W-1:0]        publish_priority;
    logic [ppta_pkg::DROP_W-1:0]        stale_dropped;

    ppta_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppta_dp
    #(
        .MAX_PEERS (MAX_PEERS),
        .ID_BITS   (ID_BITS)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (s_tuser),
        .peer_id          (s_tdata[ppta_pkg::PID_LSB +: ID_BITS]),
        .peer_peak_w      (s_tdata[ppta_pkg::PPEAK_LSB +: ppta_pkg::PEAK_W]),
        .now_ms           (s_tdata[ppta_pkg::NOW_LSB +: ppta_pkg::TIME_W]),
        .own_peak_w       (s_tdata[ppta_pkg::OPEAK_LSB +: ppta_pkg::PEAK_W]),
        .link_ready       (s_tdata[ppta_pkg::LINK_LSB]),
        .status           (status),
        .network_peak_w   (network_peak_w),
        .publish_peak_w   (publish_peak_w),
        .publish_priority (publish_priority),
        .stale_dropped    (stale_dropped)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[ppta_pkg::NET_LSB +: ppta_pkg::PEAK_W]   = network_peak_w;
        m_tdata[ppta_pkg::PUBPK_LSB +: ppta_pkg::PEAK_W] = publish_peak_w;
        m_tdata[ppta_pkg::PUBPR_LSB +: ppta_pkg::PRIO_W] = publish_priority;
        m_tdata[ppta_pkg::DROP_LSB +: ppta_pkg::DROP_W]  = stale_dropped;
    end

    assign m_tuser = status;

endmodule

/* sv/ppta_ctrl.sv */
module ppta_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ppta_pkg::dp_stat_t stat,
    output ppta_pkg::dp_cmd_t  cmd
);

    ppta_pkg::state_t state_reg;
    ppta_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppta_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ppta_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ppta_pkg::S_CHECK;
                end
            end
            ppta_pkg::S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.early_done ? ppta_pkg::S_FINISH : ppta_pkg::S_WALK;
            end
            ppta_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ppta_pkg::S_COMMIT;
                end
            end
            ppta_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ppta_pkg::S_FINISH;
            end
            ppta_pkg::S_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ppta_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppta_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ppta_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* sv/ppta_dp.sv */
module ppta_dp
#(
    parameter int MAX_PEERS = ppta_pkg::DEF_MAX_PEERS,
    parameter int ID_BITS   = ppta_pkg::DEF_ID_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppta_pkg::dp_cmd_t                    cmd,
    output ppta_pkg::dp_stat_t                   stat,
    input  logic                                 cfg_we,
    input  logic [ppta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppta_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 operation,
    input  logic [ID_BITS-1:0]                   peer_id,
    input  logic signed [ppta_pkg::PEAK_W-1:0]   peer_peak_w,
    input  logic [ppta_pkg::TIME_W-1:0]          now_ms,
    input  logic signed [ppta_pkg::PEAK_W-1:0]   own_peak_w,
    input  logic                                 link_ready,
    output ppta_pkg::status_t                    status,
    output logic signed [ppta_pkg::PEAK_W-1:0]   network_peak_w,
    output logic signed [ppta_pkg::PEAK_W-1:0]   publish_peak_w,
    output logic [ppta_pkg::PRIO_W-1:0]          publish_priority,
    output logic [ppta_pkg::DROP_W-1:0]          stale_dropped
);

    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    // configuration
    logic [ppta_pkg::CFG_W-1:0]  own_id_reg;
    logic [ppta_pkg::PRIO_W-1:0] prio_cfg_reg;
    logic [ppta_pkg::TIME_W-1:0] stale_reg;
    logic [ppta_pkg::TIME_W-1:0] period_reg;

    // table state
    logic [ID_BITS-1:0]                 key_mem  [MAX_PEERS];
    logic signed [ppta_pkg::PEAK_W-1:0] peak_mem [MAX_PEERS];
    logic [ppta_pkg::TIME_W-1:0]        seen_mem [MAX_PEERS];
    logic [MAX_PEERS-1:0]               act_reg;
    logic [CW-1:0]                      slots_used_reg;
    logic [ppta_pkg::TIME_W-1:0]        last_pub_reg;

    // item under work
    logic                               tick_reg;
    logic [ID_BITS-1:0]                 pid_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] ppeak_reg;
    logic [ppta_pkg::TIME_W-1:0]        now_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] opeak_reg;
    logic                               link_reg;

    // walk
    logic [CW-1:0]                      rd_cnt_reg;
    logic                               pend_reg;
    logic [AW-1:0]                      pidx_reg;
    logic [ID_BITS-1:0]                 key_q;
    logic signed [ppta_pkg::PEAK_W-1:0] peak_q;
    logic [ppta_pkg::TIME_W-1:0]        seen_q;
    logic                               found_reg;
    logic [AW-1:0]                      found_idx_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] mx_reg;
    logic [ppta_pkg::DROP_W-1:0]        dropped_reg;

    // result waiting for the output register
    ppta_pkg::status_t                  res_status_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] res_net_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] res_pub_peak_reg;
    logic [ppta_pkg::PRIO_W-1:0]        res_pub_prio_reg;
    logic [ppta_pkg::DROP_W-1:0]        res_dropped_reg;

    ppta_pkg::status_t                  out_status_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] out_net_reg;
    logic signed [ppta_pkg::PEAK_W-1:0] out_pub_peak_reg;
    logic [ppta_pkg::PRIO_W-1:0]        out_pub_prio_reg;
    logic [ppta_pkg::DROP_W-1:0]        out_dropped_reg;

    logic                               issue;
    logic [AW-1:0]                      raddr;
    logic                               id_ignored;
    logic                               not_due;
    logic [ppta_pkg::TIME_W-1:0]        since;
    logic [ppta_pkg::TIME_W-1:0]        age;
    logic                               entry_match;
    logic                               clr_en;
    logic                               room;
    logic                               stored;
    logic [AW-1:0]                      wslot;
    logic                               mem_we;

    assign since      = now_reg - last_pub_reg;
    assign not_due    = (since < period_reg);
    assign id_ignored = (pid_reg == '0) || (pid_reg == own_id_reg[ID_BITS-1:0]);

    assign stat.early_done = tick_reg ? not_due : id_ignored;
    assign stat.walk_done  = (rd_cnt_reg >= slots_used_reg) && !pend_reg;

    assign issue = cmd.walk && (rd_cnt_reg < slots_used_reg);
    assign raddr = rd_cnt_reg[AW-1:0];

    assign age         = now_reg - seen_q;
    assign entry_match = (key_q == pid_reg);
    assign clr_en      = pend_reg && tick_reg && act_reg[pidx_reg] && (age > stale_reg);

    assign room   = (slots_used_reg < CW'(MAX_PEERS));
    assign stored = found_reg || room;
    assign wslot  = found_reg ? found_idx_reg : slots_used_reg[AW-1:0];
    assign mem_we = cmd.commit && !tick_reg && stored;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= ppta_pkg::RST_OWN_IDENTITY;
            prio_cfg_reg <= ppta_pkg::RST_PRIORITY;
            stale_reg    <= ppta_pkg::RST_STALE_LIMIT;
            period_reg   <= ppta_pkg::RST_PUB_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppta_pkg::CFG_OWN_IDENTITY: own_id_reg   <= cfg_data;
                ppta_pkg::CFG_PRIORITY:     prio_cfg_reg <= cfg_data[ppta_pkg::PRIO_W-1:0];
                ppta_pkg::CFG_STALE_LIMIT:  stale_reg    <= cfg_data[ppta_pkg::TIME_W-1:0];
                ppta_pkg::CFG_PUB_PERIOD:   period_reg   <= cfg_data[ppta_pkg::TIME_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= '0;
            slots_used_reg <= '0;
            last_pub_reg   <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (clr_en)
            begin
                act_reg[pidx_reg] <= 1'b0;
            end
            if (mem_we)
            begin
                act_reg[wslot] <= 1'b1;
            end
            if (mem_we && !found_reg)
            begin
                slots_used_reg <= slots_used_reg + CW'(1);
            end
            if (cmd.commit && tick_reg)
            begin
                last_pub_reg <= now_reg;
            end
            if (cmd.load)
            begin
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            pend_reg <= issue;
        end
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wslot]  <= pid_reg;
            peak_mem[wslot] <= ppeak_reg;
            seen_mem[wslot] <= now_reg;
        end
        if (issue)
        begin
            key_q  <= key_mem[raddr];
            peak_q <= peak_mem[raddr];
            seen_q <= seen_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tick_reg    <= operation;
            pid_reg     <= peer_id;
            ppeak_reg   <= peer_peak_w;
            now_reg     <= now_ms;
            opeak_reg   <= own_peak_w;
            link_reg    <= link_ready;
            found_reg   <= 1'b0;
            mx_reg      <= own_peak_w;
            dropped_reg <= '0;
        end
        else if (pend_reg)
        begin
            if (tick_reg)
            begin
                if (clr_en && !(&dropped_reg))
                begin
                    dropped_reg <= dropped_reg + ppta_pkg::DROP_W'(1);
                end
            end
            else if (entry_match)
            begin
                // keys are unique, so the matching slot is left out of the maximum
                found_reg     <= 1'b1;
                found_idx_reg <= pidx_reg;
            end
            else if (act_reg[pidx_reg] && (peak_q > mx_reg))
            begin
                mx_reg <= peak_q;
            end
        end
        if (issue)
        begin
            pidx_reg <= raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_net_reg      <= '0;
            res_pub_peak_reg <= '0;
            res_pub_prio_reg <= '0;
            res_dropped_reg  <= '0;
        end
        if (cmd.check)
        begin
            res_status_reg <= tick_reg ? ppta_pkg::ST_NOT_DUE : ppta_pkg::ST_IGNORED;
        end
        if (cmd.commit)
        begin
            if (tick_reg)
            begin
                res_dropped_reg <= dropped_reg;
                if (link_reg)
                begin
                    res_status_reg   <= ppta_pkg::ST_PUBLISHED;
                    res_pub_peak_reg <= opeak_reg;
                    res_pub_prio_reg <= prio_cfg_reg;
                end
                else
                begin
                    res_status_reg <= ppta_pkg::ST_LINK_DOWN;
                end
            end
            else if (stored)
            begin
                res_status_reg <= ppta_pkg::ST_STORED;
                res_net_reg    <= (ppeak_reg > mx_reg) ? ppeak_reg : mx_reg;
            end
            else
            begin
                res_status_reg <= ppta_pkg::ST_FULL;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_net_reg      <= res_net_reg;
            out_pub_peak_reg <= res_pub_peak_reg;
            out_pub_prio_reg <= res_pub_prio_reg;
            out_dropped_reg  <= res_dropped_reg;
        end
    end

    assign status           = out_status_reg;
    assign network_peak_w   = out_net_reg;
    assign publish_peak_w   = out_pub_peak_reg;
    assign publish_priority = out_pub_prio_reg;
    assign stale_dropped    = out_dropped_reg;

endmodule

/* sv/ppta_checker.sv */
`include "peer_peak_table_with_aging_macros.svh"

module ppta_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ppta_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [ppta_pkg::STATUS_W-1:0]     m_tuser
);

    `PPTA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `PPTA_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second item taken while one is in work")
    `PPTA_ASSERT(a_net_only_stored, m_tvalid && (m_tuser != ppta_pkg::ST_STORED) |-> (m_tdata[ppta_pkg::NET_LSB +: ppta_pkg::PEAK_W] == '0), "network peak set on a result that stored nothing")
    `PPTA_ASSERT(a_pub_only_published, m_tvalid && (m_tuser != ppta_pkg::ST_PUBLISHED) |-> (m_tdata[ppta_pkg::PUBPK_LSB +: ppta_pkg::PEAK_W + ppta_pkg::PRIO_W] == '0), "publish fields set without a publish")
    `PPTA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result shown during reset")

endmodule

bind peer_peak_table_with_aging ppta_checker u_ppta_checker (.*);

/* tb/peer_peak_table_with_aging_test.sv */
module peer_peak_table_with_aging_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppta_pkg::*;

    localparam int PEERS = DEF_MAX_PEERS;

    typedef struct {
        logic                     op;
        logic [PID_W-1:0]         pid;
        logic signed [PEAK_W-1:0] peer_peak;
        logic [PRIO_W-1:0]        peer_prio;
        logic [TIME_W-1:0]        now;
        logic signed [PEAK_W-1:0] own_peak;
        logic                     link;
    } peer_msg_t;

    typedef struct {
        status_t                  status;
        logic signed [PEAK_W-1:0] net;
        logic signed [PEAK_W-1:0] pub_peak;
        logic [PRIO_W-1:0]        pub_prio;
        logic [DROP_W-1:0]        dropped;
    } verdict_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        peer_msg_t            msg;
        bit                   fixed;
        verdict_t             want;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // mirror of the peer table and registers
    logic [PID_W-1:0]         peer_key  [PEERS];
    logic signed [PEAK_W-1:0] peer_peak [PEERS];
    logic [PRIO_W-1:0]        peer_prio [PEERS];
    logic [TIME_W-1:0]        peer_seen [PEERS];
    bit                       peer_live [PEERS] = '{default: 1'b0};
    int                       slots_taken = 0;
    logic [TIME_W-1:0]        last_sweep_ms = '0;
    logic [CFG_W-1:0]         own_id_reg = RST_OWN_IDENTITY;
    logic [PRIO_W-1:0]        prio_reg = RST_PRIORITY;
    logic [TIME_W-1:0]        stale_ms = RST_STALE_LIMIT;
    logic [TIME_W-1:0]        period_ms = RST_PUB_PERIOD;

    verdict_t pending_outcomes[$];
    int       mismatches = 0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;

    peer_peak_table_with_aging i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    function automatic verdict_t track_peers(peer_msg_t m);
        verdict_t          v;
        int                slot;
        logic signed [PEAK_W-1:0] top;
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] age;
        v.status   = ST_IGNORED;
        v.net      = '0;
        v.pub_peak = '0;
        v.pub_prio = '0;
        v.dropped  = '0;
        if (m.op == OP_REPORT)
        begin
            if (m.pid != '0 && m.pid != own_id_reg)
            begin
                slot = -1;
                for (int i = 0; i < slots_taken; i++)
                    if (slot < 0 && peer_key[i] == m.pid)
                        slot = i;
                if (slot < 0 && slots_taken < PEERS)
                begin
                    slot = slots_taken;
                    slots_taken++;
                    peer_key[slot] = m.pid;
                end
                if (slot < 0)
                    v.status = ST_FULL;
                else
                begin
                    peer_peak[slot] = m.peer_peak;
                    peer_prio[slot] = m.peer_prio;
                    peer_seen[slot] = m.now;
                    peer_live[slot] = 1'b1;
                    top = m.own_peak;
                    for (int i = 0; i < slots_taken; i++)
                        if (peer_live[i] && peer_peak[i] > top)
                            top = peer_peak[i];
                    v.status = ST_STORED;
                    v.net    = top;
                end
            end
        end
        else
        begin
            since = m.now - last_sweep_ms;
            if (since < period_ms)
                v.status = ST_NOT_DUE;
            else
            begin
                last_sweep_ms = m.now;
                for (int i = 0; i < slots_taken; i++)
                begin
                    age = m.now - peer_seen[i];
                    if (peer_live[i] && age > stale_ms)
                    begin
                        peer_live[i] = 1'b0;
                        if (v.dropped != 5'd31)
                            v.dropped++;
                    end
                end
                if (m.link)
                begin
                    v.status   = ST_PUBLISHED;
                    v.pub_peak = m.own_peak;
                    v.pub_prio = prio_reg;
                end
                else
                    v.status = ST_LINK_DOWN;
            end
        end
        return v;
    endfunction

    function automatic peer_msg_t report_of(logic [PID_W-1:0] pid, logic [PEAK_W-1:0] pk,
                                            logic [PRIO_W-1:0] pr, logic [TIME_W-1:0] t,
                                            logic [PEAK_W-1:0] own);
        peer_msg_t m;
        m.op        = OP_REPORT;
        m.pid       = pid;
        m.peer_peak = pk;
        m.peer_prio = pr;
        m.now       = t;
        m.own_peak  = own;
        m.link      = 1'b1;
        return m;
    endfunction

    function automatic peer_msg_t tick_of(logic [TIME_W-1:0] t, logic [PEAK_W-1:0] own,
                                          logic link);
        peer_msg_t m;
        m      = report_of('0, '0, '0, t, own);
        m.op   = OP_TICK;
        m.link = link;
        return m;
    endfunction

    function automatic row_t item_row(peer_msg_t m);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.msg    = m;
        r.fixed  = 1'b0;
        return r;
    endfunction

    function automatic row_t known_row(peer_msg_t m, status_t st, logic [PEAK_W-1:0] net,
                                       logic [PEAK_W-1:0] pk, logic [PRIO_W-1:0] pr,
                                       logic [DROP_W-1:0] drop);
        row_t r;
        r               = item_row(m);
        r.fixed         = 1'b1;
        r.want.status   = st;
        r.want.net      = net;
        r.want.pub_peak = pk;
        r.want.pub_prio = pr;
        r.want.dropped  = drop;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        row_t r;
        r        = item_row(tick_of('0, '0, 1'b0));
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    task automatic offer(row_t r);
        logic [S_TDATA_W-1:0] d;
        verdict_t             model;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        d = '0;
        d[PID_LSB +: PID_W]    = r.msg.pid;
        d[PPEAK_LSB +: PEAK_W] = r.msg.peer_peak;
        d[PPRIO_LSB +: PRIO_W] = r.msg.peer_prio;
        d[NOW_LSB +: TIME_W]   = r.msg.now;
        d[OPEAK_LSB +: PEAK_W] = r.msg.own_peak;
        d[LINK_LSB]            = r.msg.link;
        s_tvalid <= 1'b1;
        s_tuser  <= r.msg.op;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model = track_peers(r.msg);
        pending_outcomes.push_back(r.fixed ? r.want : model);
    endtask

    // stop offering and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_OWN_IDENTITY: own_id_reg = val;
            CFG_PRIORITY:     prio_reg   = val[PRIO_W-1:0];
            CFG_STALE_LIMIT:  stale_ms   = val[TIME_W-1:0];
            CFG_PUB_PERIOD:   period_ms  = val[TIME_W-1:0];
            default:          ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // long hold-off so the block backs up and stalls its input
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_results
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
                note_mismatch("unexpected transfer, status", m_tuser, '0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch("status", m_tuser, want.status);
                if (m_tdata[NET_LSB +: PEAK_W] !== want.net)
                    note_mismatch("network_peak_w", m_tdata[NET_LSB +: PEAK_W], want.net);
                if (m_tdata[PUBPK_LSB +: PEAK_W] !== want.pub_peak)
                    note_mismatch("publish_peak_w", m_tdata[PUBPK_LSB +: PEAK_W],
                                  want.pub_peak);
                if (m_tdata[PUBPR_LSB +: PRIO_W] !== want.pub_prio)
                    note_mismatch("publish_priority", m_tdata[PUBPR_LSB +: PRIO_W],
                                  want.pub_prio);
                if (m_tdata[DROP_LSB +: DROP_W] !== want.dropped)
                    note_mismatch("stale_dropped", m_tdata[DROP_LSB +: DROP_W],
                                  want.dropped);
            end
        end
    end

    initial
    begin : stimulus
        row_t              rows[$];
        peer_msg_t         m;
        int                pick;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] step;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(known_row(tick_of(32'd0, '0, 1'b1), ST_NOT_DUE, '0, '0, '0, '0));
        rows.push_back(known_row(tick_of(32'd15000, '0, 1'b0), ST_LINK_DOWN, '0, '0, '0, '0));
        rows.push_back(known_row(report_of('0, 32'h7fff_ffff, 8'hff, 32'd15000, '0),
                                 ST_IGNORED, '0, '0, '0, '0));
        rows.push_back(known_row(report_of('1, 32'h7fff_ffff, 8'hff, 32'd16000, 32'h8000_0000),
                                 ST_STORED, 32'h7fff_ffff, '0, '0, '0));
        // differs from the previous id in the top bit only
        rows.push_back(known_row(report_of(64'h7fff_ffff_ffff_ffff, 32'h8000_0000, 8'h00,
                                           32'd17000, '0),
                                 ST_STORED, 32'h7fff_ffff, '0, '0, '0));
        rows.push_back(known_row(report_of('1, 32'hffff_fffb, 8'h80, 32'd18000, 32'h8000_0000),
                                 ST_STORED, 32'hffff_fffb, '0, '0, '0));
        rows.push_back(known_row(tick_of(32'd30000, 32'h7fff_ffff, 1'b1),
                                 ST_PUBLISHED, '0, 32'h7fff_ffff, 8'd5, '0));
        rows.push_back(cfg_row(CFG_OWN_IDENTITY, 64'h8000_0000_0000_0001));
        rows.push_back(known_row(report_of(64'h8000_0000_0000_0001, 32'd1, 8'd1, 32'd31000, '0),
                                 ST_IGNORED, '0, '0, '0, '0));
        rows.push_back(cfg_row(CFG_PRIORITY, 64'hff));
        rows.push_back(cfg_row(CFG_PUB_PERIOD, 64'd0));
        rows.push_back(cfg_row(CFG_STALE_LIMIT, 64'd0));
        // fill the remaining slots
        for (int k = 0; k < PEERS - 2; k++)
            rows.push_back(item_row(report_of(64'h1234_0000_0000_0000 + k, $urandom,
                                              8'($urandom), 32'd32000 + 10 * k, $urandom)));
        rows.push_back(known_row(report_of(64'h55, 32'd9, 8'd9, 32'd33000, '0),
                                 ST_FULL, '0, '0, '0, '0));
        // stale limit zero: every peer goes inactive
        rows.push_back(known_row(tick_of(32'd40000, 32'h8000_0000, 1'b1),
                                 ST_PUBLISHED, '0, 32'h8000_0000, 8'hff, 5'd16));
        // an inactive slot is matched again and is the only one counted
        rows.push_back(known_row(report_of('1, 32'd5, 8'd5, 32'd40001, '0),
                                 ST_STORED, 32'd5, '0, '0, '0));
        rows.push_back(cfg_row(CFG_PUB_PERIOD, 64'hffff_ffff));
        rows.push_back(cfg_row(CFG_STALE_LIMIT, 64'hffff_ffff));
        rows.push_back(known_row(tick_of(32'd40002, '0, 1'b1), ST_NOT_DUE, '0, '0, '0, '0));
        rows.push_back(cfg_row(CFG_PUB_PERIOD, 64'd1000));
        rows.push_back(cfg_row(CFG_STALE_LIMIT, 64'd60000));
        // time wrapped: both differences are taken modulo 2^32
        rows.push_back(known_row(tick_of(32'd10, '0, 1'b0), ST_LINK_DOWN, '0, '0, '0, 5'd1));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                settle();
                write_reg(rows[i].idx, rows[i].val);
            end
            else
                offer(rows[i]);
        end

        clock_ms = 32'd20000;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            calm = (phase == 7);
            case (phase % 4)
                0:       write_reg(CFG_OWN_IDENTITY, '0);
                1:       write_reg(CFG_OWN_IDENTITY, '1);
                2:       write_reg(CFG_OWN_IDENTITY, peer_key[$urandom_range(0, slots_taken - 1)]);
                default: write_reg(CFG_OWN_IDENTITY, {$urandom, $urandom});
            endcase
            write_reg(CFG_PRIORITY, phase == 0 ? 64'd0 : phase == 1 ? 64'hff
                                    : 64'($urandom_range(0, 255)));
            write_reg(CFG_STALE_LIMIT, phase == 0 ? 64'd0 : phase == 1 ? 64'hffff_ffff
                                       : 64'($urandom_range(0, 100000)));
            write_reg(CFG_PUB_PERIOD, phase == 0 ? 64'd0 : phase == 1 ? 64'hffff_ffff
                                      : 64'($urandom_range(0, 20000)));
            if (phase == 3)
                hold_req = 1'b1;
            for (int n = 0; n < 125; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       step = $urandom;
                    1, 2:    step = $urandom_range(0, 100);
                    default: step = $urandom_range(0, 8000);
                endcase
                clock_ms += step;
                m = report_of({$urandom, $urandom}, $urandom, 8'($urandom), clock_ms, $urandom);
                m.link = ($urandom_range(0, 3) != 0);
                if (pick < 30)
                    m.op = OP_TICK;
                else if (pick < 85)
                    m.pid = peer_key[$urandom_range(0, slots_taken - 1)];
                else if (pick < 90)
                    m.pid = '0;
                else if (pick < 94)
                    m.pid = own_id_reg;
                if (pick == 99)
                    m.now = $urandom;
                offer(item_row(m));
            end
        end

        settle();
        repeat (30) @(posedge clk);
        if (pending_outcomes.size() != 0)
            note_mismatch("results still outstanding", 64'(pending_outcomes.size()), '0);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
